>>> rtl/spdd_pkg.sv
// Package for the shaped-pulse dual discriminator: edge codes, register
// indexes, comparator result type and the per-bin comparator update.
// No dependencies.
`default_nettype none

package spdd_pkg;

    localparam int DATA_W  = 32;
    localparam int DECAY_W = 16;
    localparam int COUNT_W = 16;
    localparam int BIN_W   = 10;
    localparam int CHARGE_W = 26;
    localparam int ADDR_W  = 5;

    // Comparator edge codes
    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_LEAD  = 2'd1,
        EDGE_TRAIL = 2'd2
    } edge_code_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_GAIN       = 3'd0,
        REG_SHAPE_DEC  = 3'd1,
        REG_LOW_THR    = 3'd2,
        REG_LOW_HYST   = 3'd3,
        REG_HIGH_THR   = 3'd4,
        REG_HIGH_HYST  = 3'd5,
        REG_HYST_DEC   = 3'd6
    } reg_index_t;

    // Comparator state after one bin
    typedef struct packed {
        logic              above;
        logic [DATA_W-1:0] term;
        edge_code_t        code;
    } cmp_t;

    // One comparator update. Caller passes cleared state on waveform start.
    function automatic cmp_t cmp_update(
        input logic [DATA_W-1:0]  shaped,
        input logic               first,
        input logic [DATA_W-1:0]  thr,
        input logic [DATA_W-1:0]  hyst,
        input logic [DECAY_W-1:0] hdecay,
        input logic               above,
        input logic [DATA_W-1:0]  term
    );
        cmp_t                          res;
        logic [DATA_W+DECAY_W-1:0]     prod;
        logic [DATA_W-1:0]             dterm;
        logic [DATA_W-1:0]             level;
        prod  = (DATA_W+DECAY_W)'(term) * (DATA_W+DECAY_W)'(hdecay);
        dterm = prod[DATA_W+DECAY_W-1:DECAY_W];
        level = (dterm > thr) ? '0 : (thr - dterm);
        res.above = above;
        res.term  = term;
        res.code  = EDGE_NONE;
        if (first) begin
            // start above threshold: set without an edge
            if (shaped > thr) begin
                res.above = 1'b1;
                res.term  = hyst;
            end
        end else if (above) begin
            res.term = dterm;
            if (shaped < level) begin
                res.above = 1'b0;
                res.term  = '0;
                res.code  = EDGE_TRAIL;
            end
        end else if (shaped > thr) begin
            res.above = 1'b1;
            res.term  = hyst;
            res.code  = EDGE_LEAD;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/shaped_pulse_dual_discriminator.sv
// A bin goes through the input register, then one pass of shaping/comparator logic into
// the result register. Throughput: one bin per cycle while out_stall is low; the path
// is the shaping multiply-add and comparators.
// While a result waits in the output register the input register takes one more bin.
// Reset (rst_n, async, active low) clears all state but the payload registers and loads
// register defaults. Depends on spdd_pkg.
`default_nettype none

module shaped_pulse_dual_discriminator #(
    parameter int MAX_BINS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spdd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [spdd_pkg::COUNT_W-1:0]  electron_count,
    input  wire logic                          waveform_start,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [spdd_pkg::DATA_W-1:0]        shaped_value,
    output logic [1:0]                         low_edge,
    output logic [1:0]                         high_edge,
    output logic                               low_above,
    output logic                               high_above,
    output logic [spdd_pkg::BIN_W-1:0]         bin_index,
    output logic [spdd_pkg::DATA_W-1:0]        peak_value,
    output logic [spdd_pkg::BIN_W-1:0]         peak_bin,
    output logic [spdd_pkg::CHARGE_W-1:0]      charge_sum
);
    import spdd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BINS - 1);
    localparam int PROD_W = COUNT_W + DATA_W;

    // config registers
    logic [DATA_W-1:0]  gain_reg, low_thr_reg, low_hyst_reg, high_thr_reg, high_hyst_reg;
    logic [DECAY_W-1:0] shape_dec_reg, hyst_dec_reg;

    // input stage
    logic               in_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               start_reg;

    // bin state
    logic [DATA_W-1:0]   shaped_reg, low_term_reg, high_term_reg, peak_reg;
    logic                low_state_reg, high_state_reg;
    logic [CNT_W-1:0]    bin_cnt_reg, peak_idx_reg;
    logic [CHARGE_W-1:0] charge_reg;

    // result register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   shaped_out_reg, peak_out_reg;
    logic [1:0]          low_edge_reg, high_edge_reg;
    logic                low_above_reg, high_above_reg;
    logic [BIN_W-1:0]    bin_out_reg, peak_bin_reg;
    logic [CHARGE_W-1:0] charge_out_reg;

    logic accept, advance;
    logic cfg_wr;
    reg_index_t cfg_idx, rd_idx;

    // next-state values
    logic [DATA_W-1:0]   shaped_next, peak_next;
    logic [CNT_W-1:0]    bin_cnt_next, peak_idx_next;
    logic [CHARGE_W-1:0] charge_next;
    cmp_t                low_next, high_next;

    // datapath temporaries
    logic [DATA_W-1:0]   prev_shaped, prev_low_term, prev_high_term, prev_peak;
    logic                prev_low_state, prev_high_state;
    logic [CHARGE_W-1:0] prev_charge;
    logic [PROD_W-1:0]   gain_prod, decay_prod;
    logic [PROD_W:0]     shaped_sum;
    logic [CHARGE_W:0]   charge_sum_w;

    // ---------------- handshake ----------------
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[4:2]);
    assign rd_idx  = reg_index_t'(paddr[4:2]);

    always_comb
    begin
        case (rd_idx)
            REG_GAIN:      prdata = gain_reg;
            REG_SHAPE_DEC: prdata = 32'(shape_dec_reg);
            REG_LOW_THR:   prdata = low_thr_reg;
            REG_LOW_HYST:  prdata = low_hyst_reg;
            REG_HIGH_THR:  prdata = high_thr_reg;
            REG_HIGH_HYST: prdata = high_hyst_reg;
            REG_HYST_DEC:  prdata = 32'(hyst_dec_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- bin datapath ----------------
    always_comb
    begin
        // waveform start clears state before this bin
        prev_shaped     = start_reg ? '0 : shaped_reg;
        prev_low_term   = start_reg ? '0 : low_term_reg;
        prev_high_term  = start_reg ? '0 : high_term_reg;
        prev_low_state  = start_reg ? 1'b0 : low_state_reg;
        prev_high_state = start_reg ? 1'b0 : high_state_reg;
        prev_peak       = start_reg ? '0 : peak_reg;
        prev_charge     = start_reg ? '0 : charge_reg;

        if (start_reg)
            bin_cnt_next = '0;
        else if (bin_cnt_reg < CNT_LAST)
            bin_cnt_next = bin_cnt_reg + 1'b1;
        else
            bin_cnt_next = bin_cnt_reg;

        // one-pole shaping, saturating at full scale
        gain_prod  = PROD_W'(count_reg) * PROD_W'(gain_reg);
        decay_prod = PROD_W'(prev_shaped) * PROD_W'(shape_dec_reg);
        shaped_sum = (PROD_W+1)'(gain_prod)
                   + (PROD_W+1)'(decay_prod[PROD_W-1:DECAY_W]);
        shaped_next = (shaped_sum[PROD_W:DATA_W] != '0) ? '1 : shaped_sum[DATA_W-1:0];

        low_next  = cmp_update(shaped_next, start_reg, low_thr_reg, low_hyst_reg,
                               hyst_dec_reg, prev_low_state, prev_low_term);
        high_next = cmp_update(shaped_next, start_reg, high_thr_reg, high_hyst_reg,
                               hyst_dec_reg, prev_high_state, prev_high_term);

        // running peak
        if (start_reg) begin
            peak_next     = shaped_next;
            peak_idx_next = '0;
        end else if (shaped_next > prev_peak) begin
            peak_next     = shaped_next;
            peak_idx_next = bin_cnt_next;
        end else begin
            peak_next     = prev_peak;
            peak_idx_next = peak_idx_reg;
        end

        // saturating charge sum
        charge_sum_w = (CHARGE_W+1)'(prev_charge) + (CHARGE_W+1)'(count_reg);
        charge_next  = charge_sum_w[CHARGE_W] ? '1 : charge_sum_w[CHARGE_W-1:0];
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gain_reg       <= 32'd65536;
            shape_dec_reg  <= 16'd60000;
            low_thr_reg    <= '0;
            low_hyst_reg   <= '0;
            high_thr_reg   <= '0;
            high_hyst_reg  <= '0;
            hyst_dec_reg   <= 16'd60000;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            shaped_reg     <= '0;
            low_term_reg   <= '0;
            high_term_reg  <= '0;
            low_state_reg  <= 1'b0;
            high_state_reg <= 1'b0;
            peak_reg       <= '0;
            peak_idx_reg   <= '0;
            bin_cnt_reg    <= '0;
            charge_reg     <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_GAIN:      gain_reg      <= pwdata;
                    REG_SHAPE_DEC: shape_dec_reg <= pwdata[DECAY_W-1:0];
                    REG_LOW_THR:   low_thr_reg   <= pwdata;
                    REG_LOW_HYST:  low_hyst_reg  <= pwdata;
                    REG_HIGH_THR:  high_thr_reg  <= pwdata;
                    REG_HIGH_HYST: high_hyst_reg <= pwdata;
                    REG_HYST_DEC:  hyst_dec_reg  <= pwdata[DECAY_W-1:0];
                    default:       ;
                endcase
            end

            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            out_valid_reg <= advance || (out_valid_reg && out_stall);

            if (advance) begin
                shaped_reg     <= shaped_next;
                low_term_reg   <= low_next.term;
                high_term_reg  <= high_next.term;
                low_state_reg  <= low_next.above;
                high_state_reg <= high_next.above;
                peak_reg       <= peak_next;
                peak_idx_reg   <= peak_idx_next;
                bin_cnt_reg    <= bin_cnt_next;
                charge_reg     <= charge_next;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept) begin
            count_reg <= electron_count;
            start_reg <= waveform_start;
        end
        if (advance) begin
            shaped_out_reg <= shaped_next;
            low_edge_reg   <= low_next.code;
            high_edge_reg  <= high_next.code;
            low_above_reg  <= low_next.above;
            high_above_reg <= high_next.above;
            bin_out_reg    <= BIN_W'(bin_cnt_next);
            peak_out_reg   <= peak_next;
            peak_bin_reg   <= BIN_W'(peak_idx_next);
            charge_out_reg <= charge_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shaped_value = shaped_out_reg;
    assign low_edge     = low_edge_reg;
    assign high_edge    = high_edge_reg;
    assign low_above    = low_above_reg;
    assign high_above   = high_above_reg;
    assign bin_index    = bin_out_reg;
    assign peak_value   = peak_out_reg;
    assign peak_bin     = peak_bin_reg;
    assign charge_sum   = charge_out_reg;

    // ---------------- assertions ----------------
    // a leading edge leaves the comparator above
    a_low_lead_above: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && low_edge == EDGE_LEAD) |-> low_above)
        else $error("low leading edge without above state");

    // a trailing edge leaves the comparator below
    a_high_trail_below: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && high_edge == EDGE_TRAIL) |-> !high_above)
        else $error("high trailing edge with above state");

    // peak includes the current bin
    a_peak_ge_shaped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_value >= shaped_value))
        else $error("peak below shaped value");

    // a waveform start restarts the bin counter
    a_start_clears_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && start_reg) |=> (bin_cnt_reg == '0 && peak_idx_reg == '0))
        else $error("bin counter not cleared on waveform start");

endmodule

`default_nettype wire

>>> tb/shaped_pulse_dual_discriminator_tb.sv
// Self-checking testbench for shaped_pulse_dual_discriminator: directed bins,
// random pulse trains under several settings, back-pressure and a long waveform.
// Depends on spdd_pkg and the shaped_pulse_dual_discriminator RTL.
module shaped_pulse_dual_discriminator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spdd_pkg::*;

    localparam int MAX_BINS    = 1024;
    localparam int CYCLE_LIMIT = 200000;

    // Expected outcome of one bin
    typedef struct packed {
        logic [31:0] shaped;
        edge_code_t  low_edge;
        edge_code_t  high_edge;
        logic        low_above;
        logic        high_above;
        logic [9:0]  bin;
        logic [31:0] peak;
        logic [9:0]  peak_bin;
        logic [25:0] charge;
    } bin_result_t;

    // Register settings
    typedef struct packed {
        logic [31:0] gain;
        logic [15:0] shape_decay;
        logic [31:0] low_thr;
        logic [31:0] low_hyst;
        logic [31:0] high_thr;
        logic [31:0] high_hyst;
        logic [15:0] hyst_decay;
    } dsc_cfg_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [ADDR_W-1:0]     paddr          = '0;
    logic [31:0]           pwdata         = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [COUNT_W-1:0]    electron_count = '0;
    logic                  waveform_start = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [DATA_W-1:0]     shaped_value;
    logic [1:0]            low_edge;
    logic [1:0]            high_edge;
    logic                  low_above;
    logic                  high_above;
    logic [BIN_W-1:0]      bin_index;
    logic [DATA_W-1:0]     peak_value;
    logic [BIN_W-1:0]      peak_bin;
    logic [CHARGE_W-1:0]   charge_sum;

    shaped_pulse_dual_discriminator uut (.*);

    always #10 clk = ~clk;

    // Predictor copy of the registers (reset values) and of the block state
    dsc_cfg_t cfg = '{gain: 32'h0001_0000, shape_decay: 16'd60000, low_thr: '0,
                      low_hyst: '0, high_thr: '0, high_hyst: '0, hyst_decay: 16'd60000};
    logic [31:0] m_shaped     = '0;
    logic        m_low_above  = 1'b0;
    logic        m_high_above = 1'b0;
    logic [31:0] m_low_term   = '0;
    logic [31:0] m_high_term  = '0;
    logic [31:0] m_peak       = '0;
    logic [9:0]  m_peak_bin   = '0;
    logic [9:0]  m_bin        = '0;
    logic [25:0] m_charge     = '0;

    bin_result_t pending_bins[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_hold    = 0;
    int          error_count   = 0;
    int          result_count  = 0;
    int          cycle_count   = 0;

    // One comparator: leading edge above thr, trailing below thr minus decaying term
    function automatic edge_code_t discriminate(
        input logic [31:0] shaped,
        input logic        first,
        input logic [31:0] thr,
        input logic [31:0] hyst,
        inout logic        above,
        inout logic [31:0] term
    );
        edge_code_t  code;
        logic [47:0] prod;
        logic [31:0] level;
        code = EDGE_NONE;
        if (first) begin
            // waveform starting above: set quietly
            if (shaped > thr) begin
                above = 1'b1;
                term  = hyst;
            end
        end else if (above) begin
            prod  = 48'(term) * 48'(cfg.hyst_decay);
            term  = prod[47:16];
            level = (term > thr) ? 32'd0 : thr - term;
            if (shaped < level) begin
                above = 1'b0;
                term  = '0;
                code  = EDGE_TRAIL;
            end
        end else if (shaped > thr) begin
            above = 1'b1;
            term  = hyst;
            code  = EDGE_LEAD;
        end
        return code;
    endfunction

    // Advance the predicted state by one bin and return the expected outcome
    function automatic bin_result_t shape_and_discriminate(input logic [15:0] count,
                                                           input logic first);
        bin_result_t r;
        logic [47:0] decayed;
        logic [49:0] sum;
        logic [26:0] charge;
        if (first) begin
            m_shaped     = '0;
            m_low_term   = '0;
            m_high_term  = '0;
            m_peak       = '0;
            m_charge     = '0;
            m_peak_bin   = '0;
            m_bin        = '0;
            m_low_above  = 1'b0;
            m_high_above = 1'b0;
        end else if (m_bin < 10'(MAX_BINS - 1)) begin
            m_bin = m_bin + 10'd1;
        end

        // RC shaping, saturating at full scale
        decayed  = 48'(m_shaped) * 48'(cfg.shape_decay);
        sum      = 50'(count) * 50'(cfg.gain) + 50'(decayed[47:16]);
        m_shaped = (sum > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];

        r.low_edge  = discriminate(m_shaped, first, cfg.low_thr, cfg.low_hyst,
                                   m_low_above, m_low_term);
        r.high_edge = discriminate(m_shaped, first, cfg.high_thr, cfg.high_hyst,
                                   m_high_above, m_high_term);

        if (first) begin
            m_peak     = m_shaped;
            m_peak_bin = '0;
        end else if (m_shaped > m_peak) begin
            m_peak     = m_shaped;
            m_peak_bin = m_bin;
        end

        charge   = 27'(m_charge) + 27'(count);
        m_charge = (charge > 27'h3FF_FFFF) ? 26'h3FF_FFFF : charge[25:0];

        r.shaped     = m_shaped;
        r.low_above  = m_low_above;
        r.high_above = m_high_above;
        r.bin        = m_bin;
        r.peak       = m_peak;
        r.peak_bin   = m_peak_bin;
        r.charge     = m_charge;
        return r;
    endfunction

    function automatic logic [31:0] limit32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (error_count < 40)
            $display("ERROR result %0d %s: got %0h, expected %0h", result_count, field,
                     got, want);
        error_count++;
    endtask

    // Offer one bin; returns at the falling edge after the transaction
    task automatic send_bin(input logic [15:0] count, input logic start);
        bin_result_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        electron_count <= count;
        waveform_start <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = shape_and_discriminate(count, start);
        pending_bins = {pending_bins, want};
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_bins.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Setup then access phase; leaves the bus selected for the next write
    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
    endtask

    // Write all registers; only called with the block idle
    task automatic load_config(input dsc_cfg_t c);
        apb_write(REG_GAIN,      c.gain);
        apb_write(REG_SHAPE_DEC, 32'(c.shape_decay));
        apb_write(REG_LOW_THR,   c.low_thr);
        apb_write(REG_LOW_HYST,  c.low_hyst);
        apb_write(REG_HIGH_THR,  c.high_thr);
        apb_write(REG_HIGH_HYST, c.high_hyst);
        apb_write(REG_HYST_DEC,  32'(c.hyst_decay));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg = c;
    endtask

    // Thresholds scaled to the pulse heights that will be sent
    function automatic dsc_cfg_t random_cfg(input int amp_max);
        dsc_cfg_t    c;
        logic [63:0] span;
        case ($urandom_range(0, 5))
            0, 1:    c.gain = 32'h0001_0000;
            2, 3:    c.gain = $urandom_range(32'h100, 32'h4_0000);
            4:       c.gain = $urandom;
            default: c.gain = '0;
        endcase
        c.shape_decay = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(40000, 65535));
        c.hyst_decay  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(40000, 65535));
        span       = 64'(amp_max) * 64'(c.gain);
        c.low_thr  = limit32(span * $urandom_range(1, 40) / 100);
        c.high_thr = limit32(span * $urandom_range(30, 130) / 100);
        c.low_hyst = ($urandom_range(0, 4) == 0) ? 32'($urandom)
                   : limit32(64'(c.low_thr) * $urandom_range(0, 90) / 100);
        c.high_hyst = ($urandom_range(0, 4) == 0) ? 32'($urandom)
                    : limit32(64'(c.high_thr) * $urandom_range(0, 90) / 100);
        return c;
    endfunction

    // One waveform: start bin, baseline noise and a fast-rise, decaying pulse
    task automatic send_waveform(input int len, input int amp_max, input int noise);
        int pulse_at;
        int amp;
        int level;
        int b;
        pulse_at = $urandom_range(0, len - 1);
        amp      = $urandom_range(1, amp_max);
        for (b = 0; b < len; b++) begin
            level = $urandom_range(0, noise);
            if (b >= pulse_at && b < pulse_at + 4)
                level += amp >> (2 * (b - pulse_at));
            if (level > 65535) level = 65535;
            send_bin(16'(level), b == 0);
        end
    endtask

    // Bins before any waveform start continue from the cleared state
    task automatic test_start_without_waveform_flag();
        send_bin(16'd5, 1'b0);
        send_bin(16'd0, 1'b0);
        send_bin(16'd0, 1'b0);
        drain_results();
    endtask

    // Leading edges on both comparators, trailing on the low one
    task automatic test_leading_and_trailing_edges();
        logic [15:0] counts[10] = '{16'd0, 16'd0, 16'd200, 16'd2000, 16'd0,
                                    16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        int b;
        load_config('{gain: 32'h0001_0000, shape_decay: 16'h8000,
                      low_thr: 32'h0064_0000, low_hyst: 32'h0032_0000,
                      high_thr: 32'h03E8_0000, high_hyst: 32'hFFFF_FFFF,
                      hyst_decay: 16'h8000});
        for (b = 0; b < 10; b++) send_bin(counts[b], b == 0);
        drain_results();
    endtask

    // Waveform start above threshold sets the comparators with no edge
    task automatic test_start_above_threshold();
        send_bin(16'd5000, 1'b1);
        send_bin(16'd0, 1'b0);
        send_bin(16'd5000, 1'b1);
        send_bin(16'd0, 1'b1);
        drain_results();
    endtask

    // Full-scale gain and counts: shaped value saturates, thresholds unreachable
    task automatic test_saturating_extremes();
        load_config('{gain: 32'hFFFF_FFFF, shape_decay: 16'hFFFF,
                      low_thr: 32'hFFFF_FFFF, low_hyst: '0,
                      high_thr: 32'hFFFF_FFFF, high_hyst: '0, hyst_decay: '0});
        send_bin(16'hFFFF, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'h0000, 1'b0);
        send_bin(16'h0001, 1'b0);
        drain_results();
    endtask

    // Hysteresis larger than the threshold pins the trailing level at zero
    task automatic test_hysteresis_floor();
        load_config('{gain: 32'd1, shape_decay: '0,
                      low_thr: '0, low_hyst: 32'hFFFF_FFFF,
                      high_thr: 32'd1, high_hyst: 32'hFFFF_FFFF, hyst_decay: 16'hFFFF});
        send_bin(16'd0, 1'b1);
        send_bin(16'd3, 1'b0);
        send_bin(16'd0, 1'b0);
        send_bin(16'd0, 1'b0);
        drain_results();
    endtask

    // Mostly well-formed waveforms, some noise and broken sequences
    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        int sent;
        int chunk_end;
        int len;
        int amp_max;
        int noise;
        drain_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n) begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       amp_max = 20;
                1:       amp_max = 400;
                2:       amp_max = 5000;
                default: amp_max = 65535;
            endcase
            noise = $urandom_range(0, amp_max / 8);
            load_config(random_cfg(amp_max));
            chunk_end = sent + 70;
            while (sent < chunk_end && sent < n) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_bin(16'($urandom), $urandom_range(0, 7) == 0);
                    sent++;
                end else begin
                    len = $urandom_range(4, 40);
                    send_waveform(len, amp_max, noise);
                    sent += len;
                end
            end
        end
        drain_results();
    endtask

    // Long receiver hold-off while bins keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain_results();
        load_config(random_cfg(400));
        @(posedge clk);
        stall_hold = 300;
        @(negedge clk);
        repeat (3) send_waveform(15, 400, 20);
        drain_results();
    endtask

    // Waveform longer than the bin range: bin counter and charge saturate
    task automatic test_long_waveform();
        dsc_cfg_t c;
        int       b;
        drain_results();
        c      = random_cfg(65535);
        c.gain = 32'h0001_0000;
        load_config(c);
        for (b = 0; b < 1060; b++)
            send_bin(16'($urandom_range(64600, 65535)), b == 0);
        drain_results();
    endtask

    // Receiver stall: long hold when requested, else random
    always @(negedge clk) begin
        if (stall_hold > 0) begin
            out_stall <= 1'b1;
            stall_hold--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk) begin : check_results
        bin_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_bins.size() == 0) begin
                flag_mismatch("transaction with none expected", shaped_value, '0);
            end else begin
                want = pending_bins.pop_front();
                if (shaped_value !== want.shaped)
                    flag_mismatch("shaped_value", shaped_value, want.shaped);
                if (low_edge !== want.low_edge)
                    flag_mismatch("low_edge", 32'(low_edge), 32'(want.low_edge));
                if (high_edge !== want.high_edge)
                    flag_mismatch("high_edge", 32'(high_edge), 32'(want.high_edge));
                if (low_above !== want.low_above)
                    flag_mismatch("low_above", 32'(low_above), 32'(want.low_above));
                if (high_above !== want.high_above)
                    flag_mismatch("high_above", 32'(high_above), 32'(want.high_above));
                if (bin_index !== want.bin)
                    flag_mismatch("bin_index", 32'(bin_index), 32'(want.bin));
                if (peak_value !== want.peak)
                    flag_mismatch("peak_value", peak_value, want.peak);
                if (peak_bin !== want.peak_bin)
                    flag_mismatch("peak_bin", 32'(peak_bin), 32'(want.peak_bin));
                if (charge_sum !== want.charge)
                    flag_mismatch("charge_sum", 32'(charge_sum), 32'(want.charge));
            end
            result_count++;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("shaped_pulse_dual_discriminator test failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 82;
        test_start_without_waveform_flag();
        test_leading_and_trailing_edges();
        test_start_above_threshold();
        test_saturating_extremes();
        test_hysteresis_floor();

        test_random_traffic(40, 30, 82);
        test_random_traffic(40, 82, 30);
        test_random_traffic(40, 0, 0);
        test_output_backpressure();
        test_long_waveform();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("shaped_pulse_dual_discriminator test passed");
        else
            $display("shaped_pulse_dual_discriminator test failed");
        $finish;
    end

endmodule
